// ----- design/nls_pkg.sv -----
// Shared types and constants for the numeric literal scanner.
// Used by the output queue and by the scanner top level; no dependencies.
package nls_pkg;

    localparam int OUT_DEPTH    = 4;
    localparam int CNT_BITS     = 3;
    localparam int OUT_POS_BITS = 20;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_LITERAL = 3'd1,
        MODE_BLOCK   = 3'd2,
        MODE_LINE    = 3'd3,
        MODE_MACRO   = 3'd4
    } mode_t;

    typedef enum logic {
        KIND_INT   = 1'b0,
        KIND_FLOAT = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [OUT_POS_BITS-1:0]  start_pos;
        logic [OUT_POS_BITS-1:0]  end_pos;
        logic signed [31:0]       int_value;
        logic                     last;
    } beat_t;

endpackage

// ----- design/nls_out_fifo.sv -----
// Result queue of the numeric literal scanner: takes up to two result beats per
// cycle and hands out one per cycle while out_ready is high. Depends on nls_pkg.
module nls_out_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push0,
    input  logic          push1,
    input  nls_pkg::beat_t d0,
    input  nls_pkg::beat_t d1,
    output logic          room,
    output logic          out_valid,
    input  logic          out_ready,
    output nls_pkg::beat_t out_beat
);

    nls_pkg::beat_t                   mem_reg  [nls_pkg::OUT_DEPTH];
    nls_pkg::beat_t                   mem_next [nls_pkg::OUT_DEPTH];
    logic [nls_pkg::CNT_BITS-1:0]     cnt_reg;
    logic [nls_pkg::CNT_BITS-1:0]     cnt_next;
    logic [nls_pkg::CNT_BITS-1:0]     base;
    logic                             pop;

    assign out_valid = (cnt_reg != '0);
    assign out_beat  = mem_reg[0];
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= nls_pkg::CNT_BITS'(nls_pkg::OUT_DEPTH - 2));

    always_comb
    begin
        base = cnt_reg - nls_pkg::CNT_BITS'(pop);
        for (int k = 0; k < nls_pkg::OUT_DEPTH; k++)
        begin
            mem_next[k] = pop ? mem_reg[(k + 1) % nls_pkg::OUT_DEPTH] : mem_reg[k];
            if (push0 && (base == nls_pkg::CNT_BITS'(k)))
            begin
                mem_next[k] = d0;
            end
            if (push1 && ((base + nls_pkg::CNT_BITS'(1)) == nls_pkg::CNT_BITS'(k)))
            begin
                mem_next[k] = d1;
            end
        end
        cnt_next = base + nls_pkg::CNT_BITS'(push0) + nls_pkg::CNT_BITS'(push1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_reg <= mem_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= nls_pkg::CNT_BITS'(nls_pkg::OUT_DEPTH))
        else $error("result queue holds more beats than its depth");

    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push1 |-> push0)
        else $error("second result pushed without a first");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push0 |-> $past(1'b1) && (cnt_reg <= nls_pkg::CNT_BITS'(nls_pkg::OUT_DEPTH - 2)))
        else $error("result pushed while the queue had no room for two beats");

endmodule

// ----- design/numeric_literal_scanner_unit.sv -----
// Numeric literal scanner: finds integer and float literals in a character stream.
// Each character waits in a lookahead register until the next one or end of text.
// Throughput: one character per cycle while not stalled; one pass of logic per beat.
// Results go through a four-beat queue; input stalls while more than two wait.
// Reset (asynchronous, active low) clears the scan state and empties the queue.
// Depends on nls_pkg and nls_out_fifo.
module numeric_literal_scanner_unit
#(
    parameter int POS_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // start_pos[19:0], end_pos[39:20], int_value[71:40]
    output logic [0:0]  m_tuser,   // literal_kind[0]
    output logic        m_tlast    // last_in_run
);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam int FORM_DOT   = 0;
    localparam int FORM_LASTF = 1;
    localparam int FORM_BAD   = 2;

    typedef struct packed {
        nls_pkg::mode_t      mode;
        logic                skip_next;
        logic [7:0]          before_char;
        logic [POS_BITS-1:0] literal_start;
        logic                float_seen;
        logic [31:0]         accumulator;
        logic                overflowed;
        logic                negative;
        logic [3:0]          float_form;
    } st_t;

    typedef struct packed {
        st_t            st;
        logic           hit;
        nls_pkg::beat_t res;
    } scan_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               (c == 8'hAA) || (c == 8'hB5) || (c == 8'hBA) ||
               ((c >= 8'hC0) && (c != 8'hD7) && (c != 8'hF7));
    endfunction

    function automatic logic [nls_pkg::OUT_POS_BITS-1:0] out_pos(logic [POS_BITS-1:0] p);
        logic [POS_BITS+nls_pkg::OUT_POS_BITS-1:0] wide;
        wide = {{nls_pkg::OUT_POS_BITS{1'b0}}, p};
        return wide[nls_pkg::OUT_POS_BITS-1:0];
    endfunction

    function automatic scan_t close_lit(st_t s, logic [POS_BITS-1:0] e);
        scan_t o;
        o = '0;
        o.st = s;
        o.st.mode = nls_pkg::MODE_NORMAL;
        o.res.start_pos = out_pos(s.literal_start);
        o.res.end_pos = out_pos(e);
        if (s.float_seen)
        begin
            o.res.kind = nls_pkg::KIND_FLOAT;
            o.hit = !s.float_form[FORM_BAD];
        end
        else
        begin
            o.res.kind = nls_pkg::KIND_INT;
            if (s.negative)
            begin
                o.hit = !s.overflowed && (s.accumulator <= 32'h8000_0000);
                o.res.int_value = -s.accumulator;
            end
            else
            begin
                o.hit = !s.overflowed && (s.accumulator <= 32'h7FFF_FFFF);
                o.res.int_value = s.accumulator;
            end
        end
        return o;
    endfunction

    function automatic st_t start_lit(st_t s, logic [7:0] p, logic [POS_BITS-1:0] i);
        st_t o;
        o = s;
        o.mode = nls_pkg::MODE_LITERAL;
        o.literal_start = i;
        o.float_seen = 1'b0;
        o.accumulator = '0;
        o.overflowed = 1'b0;
        o.negative = (p == CH_MINUS);
        o.float_form = '0;
        return o;
    endfunction

    function automatic st_t feed(st_t s, logic [7:0] p);
        st_t         o;
        logic [7:0]  dig;
        logic [35:0] m;
        o = s;
        dig = p - CH_0;
        m = {4'b0, s.accumulator} * 36'd10 + {32'b0, dig[3:0]};
        if (p != CH_MINUS)
        begin
            if (o.float_form[FORM_LASTF])
            begin
                o.float_form[FORM_BAD] = 1'b1;
            end
            if (is_digit(p))
            begin
                o.float_form[FORM_LASTF] = 1'b0;
                if (!o.overflowed)
                begin
                    if (m > 36'h0_8000_0000)
                    begin
                        o.overflowed = 1'b1;
                    end
                    else
                    begin
                        o.accumulator = m[31:0];
                    end
                end
            end
            else if (p == CH_DOT)
            begin
                o.float_form[FORM_LASTF] = 1'b0;
                if (o.float_form[FORM_DOT])
                begin
                    o.float_form[FORM_BAD] = 1'b1;
                end
                o.float_form[FORM_DOT] = 1'b1;
            end
            else if (p == CH_F)
            begin
                o.float_form[FORM_LASTF] = 1'b1;
            end
        end
        return o;
    endfunction

    function automatic scan_t scan(st_t s, logic [7:0] p, logic [POS_BITS-1:0] i,
                                   logic [7:0] nx, logic nvalid);
        scan_t o;
        scan_t cl;
        o = '0;
        o.st = s;
        if (s.skip_next)
        begin
            o.st.skip_next = 1'b0;
        end
        else if (s.mode == nls_pkg::MODE_BLOCK)
        begin
            if ((p == CH_STAR) && nvalid && (nx == CH_SLASH))
            begin
                o.st.mode = nls_pkg::MODE_NORMAL;
                o.st.skip_next = 1'b1;
            end
        end
        else if ((s.mode == nls_pkg::MODE_LINE) || (s.mode == nls_pkg::MODE_MACRO))
        begin
            if (p == CH_NL)
            begin
                o.st.mode = nls_pkg::MODE_NORMAL;
            end
        end
        else
        begin
            if (s.mode == nls_pkg::MODE_LITERAL)
            begin
                if ((p == CH_F) || (p == CH_DOT))
                begin
                    o.st.float_seen = 1'b1;
                end
                else if (!is_digit(p))
                begin
                    cl = close_lit(o.st, i - POS_BITS'(1));
                    o.st = cl.st;
                    o.hit = cl.hit;
                    o.res = cl.res;
                end
            end
            else
            begin
                o.st.mode = nls_pkg::MODE_NORMAL;
            end
            if (p == CH_HASH)
            begin
                o.st.mode = nls_pkg::MODE_MACRO;
            end
            else if (p == CH_SLASH)
            begin
                if (nvalid && (nx == CH_SLASH))
                begin
                    o.st.mode = nls_pkg::MODE_LINE;
                    o.st.skip_next = 1'b1;
                end
                else if (nvalid && (nx == CH_STAR))
                begin
                    o.st.mode = nls_pkg::MODE_BLOCK;
                    o.st.skip_next = 1'b1;
                end
            end
            else if (is_digit(p) && (o.st.mode != nls_pkg::MODE_LITERAL))
            begin
                if (!is_letter(s.before_char))
                begin
                    o.st = start_lit(o.st, p, i);
                end
            end
            else if ((p == CH_MINUS) && (o.st.mode != nls_pkg::MODE_LITERAL) && nvalid &&
                     is_digit(nx))
            begin
                if (!is_letter(s.before_char))
                begin
                    o.st = start_lit(o.st, p, i);
                end
            end
            if (o.st.mode == nls_pkg::MODE_LITERAL)
            begin
                o.st = feed(o.st, p);
            end
        end
        o.st.before_char = p;
        return o;
    endfunction

    st_t                 st_reg;
    st_t                 st_next;
    logic [7:0]          held_char_reg;
    logic [7:0]          held_char_next;
    logic                held_valid_reg;
    logic                held_valid_next;
    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pos_next;

    st_t                 st_a;
    logic [POS_BITS-1:0] pos_a;
    scan_t               r1;
    scan_t               r2;
    scan_t               r3;
    logic                flush_hit;
    logic [1:0]          res_cnt;
    nls_pkg::beat_t      res0;
    nls_pkg::beat_t      res1;
    logic                accept;
    logic                room;
    nls_pkg::beat_t      out_beat;

    assign accept = s_tvalid && s_tready;
    assign s_tready = room;

    always_comb
    begin
        r1 = '0;
        st_a = st_reg;
        pos_a = pos_reg;
        if (held_valid_reg)
        begin
            r1 = scan(st_reg, held_char_reg, pos_reg, s_tdata, 1'b1);
            st_a = r1.st;
            pos_a = pos_reg + POS_BITS'(1);
        end
        r2 = scan(st_a, s_tdata, pos_a, 8'h00, 1'b0);
        r3 = close_lit(r2.st, pos_a);
        flush_hit = (r2.st.mode == nls_pkg::MODE_LITERAL) && r3.hit;

        res0 = '0;
        res1 = '0;
        res_cnt = 2'd0;
        if (r1.hit)
        begin
            res0 = r1.res;
            res_cnt = 2'd1;
        end
        if (s_tlast && r2.hit && (res_cnt != 2'd2))
        begin
            if (res_cnt == 2'd0)
            begin
                res0 = r2.res;
            end
            else
            begin
                res1 = r2.res;
            end
            res_cnt = res_cnt + 2'd1;
        end
        if (s_tlast && flush_hit && (res_cnt != 2'd2))
        begin
            if (res_cnt == 2'd0)
            begin
                res0 = r3.res;
            end
            else
            begin
                res1 = r3.res;
            end
            res_cnt = res_cnt + 2'd1;
        end
        res0.last = (res_cnt == 2'd1);
        res1.last = 1'b1;

        st_next = st_reg;
        held_char_next = held_char_reg;
        held_valid_next = held_valid_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                st_next = '0;
                held_char_next = '0;
                held_valid_next = 1'b0;
                pos_next = '0;
            end
            else
            begin
                st_next = st_a;
                held_char_next = s_tdata;
                held_valid_next = 1'b1;
                pos_next = pos_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
            held_char_reg <= '0;
            held_valid_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            held_char_reg <= held_char_next;
            held_valid_reg <= held_valid_next;
            pos_reg <= pos_next;
        end
    end

    nls_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (accept && (res_cnt != 2'd0)),
        .push1     (accept && (res_cnt == 2'd2)),
        .d0        (res0),
        .d1        (res1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat)
    );

    assign m_tdata = {out_beat.int_value, out_beat.end_pos, out_beat.start_pos};
    assign m_tuser = out_beat.kind;
    assign m_tlast = out_beat.last;

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> !held_valid_reg && (pos_reg == '0) &&
                                (st_reg.mode == nls_pkg::MODE_NORMAL))
        else $error("scan state not cleared after the final character");

    a_hold_char: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tlast) |=> held_valid_reg && (held_char_reg == $past(s_tdata)))
        else $error("accepted character not held for lookahead");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tlast && held_valid_reg) |=>
            (pos_reg == $past(pos_reg) + POS_BITS'(1)))
        else $error("position did not advance by one");

    a_two_only_at_eot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (res_cnt == 2'd2)) |-> s_tlast)
        else $error("two results from a character that is not the final one");

endmodule

// ----- test/numeric_literal_scanner_unit_tb.sv -----
// Self-checking testbench for numeric_literal_scanner_unit: drives character texts on the
// input stream and checks every literal beat against a scanner predictor kept in the bench.
// Depends on nls_pkg and the scanner RTL.
module numeric_literal_scanner_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [3:0] FORM_DOT   = 4'd1;
    localparam logic [3:0] FORM_LASTF = 4'd2;
    localparam logic [3:0] FORM_BAD   = 4'd4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // Scanner state as predicted by the bench.
    nls_pkg::mode_t sc_mode;
    logic [7:0]  sc_held;
    logic        sc_held_ok;
    logic [7:0]  sc_prev;
    logic [19:0] sc_pos;
    logic        sc_skip;
    logic [19:0] sc_lit_start;
    logic        sc_is_float;
    logic [31:0] sc_acc;
    logic        sc_ovf;
    logic        sc_neg;
    logic [3:0]  sc_form;

    nls_pkg::beat_t step_beats [2];
    int             step_count;
    nls_pkg::beat_t pending_literals [$];
    logic [7:0]     text_buf [$];

    int gap_pct = 0;
    int stall_pct = 0;
    int hold_len = 0;
    int hold_count;
    int quiet_cycles = 0;
    int err_count = 0;
    int literals_checked = 0;
    int chars_sent = 0;
    int texts_sent = 0;

    numeric_literal_scanner_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            return 1'b1;
        if (c == 8'hAA || c == 8'hB5 || c == 8'hBA)
            return 1'b1;
        return c >= 8'hC0 && c != 8'hD7 && c != 8'hF7;
    endfunction

    function automatic void scanner_clear();
        sc_mode      = nls_pkg::MODE_NORMAL;
        sc_held      = 8'd0;
        sc_held_ok   = 1'b0;
        sc_prev      = 8'd0;
        sc_pos       = 20'd0;
        sc_skip      = 1'b0;
        sc_lit_start = 20'd0;
        sc_is_float  = 1'b0;
        sc_acc       = 32'd0;
        sc_ovf       = 1'b0;
        sc_neg       = 1'b0;
        sc_form      = 4'd0;
    endfunction

    function automatic void emit_literal(nls_pkg::kind_t kind, logic [19:0] last_pos,
                                         logic [31:0] value);
        if (step_count >= 2)
            return;
        step_beats[step_count].kind      = kind;
        step_beats[step_count].start_pos = sc_lit_start;
        step_beats[step_count].end_pos   = last_pos;
        step_beats[step_count].int_value = value;
        step_beats[step_count].last      = 1'b0;
        step_count++;
    endfunction

    function automatic void close_literal(logic [19:0] last_pos);
        logic [31:0] limit;
        sc_mode = nls_pkg::MODE_NORMAL;
        if (sc_is_float)
        begin
            if ((sc_form & FORM_BAD) == 4'd0)
                emit_literal(nls_pkg::KIND_FLOAT, last_pos, 32'd0);
        end
        else
        begin
            limit = sc_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (!sc_ovf && sc_acc <= limit)
                emit_literal(nls_pkg::KIND_INT, last_pos, sc_neg ? 32'd0 - sc_acc : sc_acc);
        end
    endfunction

    function automatic void open_literal(logic [19:0] pos, logic [7:0] p);
        sc_mode      = nls_pkg::MODE_LITERAL;
        sc_lit_start = pos;
        sc_is_float  = 1'b0;
        sc_acc       = 32'd0;
        sc_ovf       = 1'b0;
        sc_neg       = (p == CH_MINUS);
        sc_form      = 4'd0;
    endfunction

    function automatic void accumulate_char(logic [7:0] p);
        logic [39:0] grown;
        if (p == CH_MINUS)
            return;
        if ((sc_form & FORM_LASTF) != 4'd0)
            sc_form |= FORM_BAD;
        if (is_digit(p))
        begin
            sc_form &= ~FORM_LASTF;
            if (!sc_ovf)
            begin
                grown = {8'd0, sc_acc} * 40'd10 + {32'd0, p - CH_ZERO};
                if (grown > 40'h80000000)
                    sc_ovf = 1'b1;
                else
                    sc_acc = grown[31:0];
            end
        end
        else if (p == CH_DOT)
        begin
            sc_form &= ~FORM_LASTF;
            if ((sc_form & FORM_DOT) != 4'd0)
                sc_form |= FORM_BAD;
            sc_form |= FORM_DOT;
        end
        else if (p == CH_F)
        begin
            sc_form |= FORM_LASTF;
        end
    endfunction

    function automatic void scan_char(logic [7:0] p, logic [19:0] pos, logic [7:0] nx,
                                      bit nx_ok);
        if (sc_skip)
        begin
            sc_skip = 1'b0;
            sc_prev = p;
            return;
        end
        if (sc_mode == nls_pkg::MODE_BLOCK)
        begin
            if (p == CH_STAR && nx_ok && nx == CH_SLASH)
            begin
                sc_mode = nls_pkg::MODE_NORMAL;
                sc_skip = 1'b1;
            end
            sc_prev = p;
            return;
        end
        if (sc_mode == nls_pkg::MODE_LINE || sc_mode == nls_pkg::MODE_MACRO)
        begin
            if (p == CH_NEWLINE)
                sc_mode = nls_pkg::MODE_NORMAL;
            sc_prev = p;
            return;
        end
        if (sc_mode == nls_pkg::MODE_LITERAL)
        begin
            if (p == CH_F || p == CH_DOT)
                sc_is_float = 1'b1;
            else if (!is_digit(p))
                close_literal(pos - 20'd1);
        end
        else
        begin
            sc_mode = nls_pkg::MODE_NORMAL;
        end

        if (p == CH_HASH)
        begin
            sc_mode = nls_pkg::MODE_MACRO;
        end
        else if (p == CH_SLASH)
        begin
            if (nx_ok && nx == CH_SLASH)
            begin
                sc_mode = nls_pkg::MODE_LINE;
                sc_skip = 1'b1;
            end
            else if (nx_ok && nx == CH_STAR)
            begin
                sc_mode = nls_pkg::MODE_BLOCK;
                sc_skip = 1'b1;
            end
        end
        else if (is_digit(p) && sc_mode != nls_pkg::MODE_LITERAL)
        begin
            if (!is_letter(sc_prev))
                open_literal(pos, p);
        end
        else if (p == CH_MINUS && sc_mode != nls_pkg::MODE_LITERAL && nx_ok && is_digit(nx))
        begin
            if (!is_letter(sc_prev))
                open_literal(pos, p);
        end
        if (sc_mode == nls_pkg::MODE_LITERAL)
            accumulate_char(p);
        sc_prev = p;
    endfunction

    function automatic void predict_literals(logic [7:0] c, logic eot);
        step_count = 0;
        if (sc_held_ok)
        begin
            scan_char(sc_held, sc_pos, c, 1'b1);
            sc_pos = sc_pos + 20'd1;
        end
        if (eot)
        begin
            scan_char(c, sc_pos, 8'd0, 1'b0);
            if (sc_mode == nls_pkg::MODE_LITERAL)
                close_literal(sc_pos);
            scanner_clear();
        end
        else
        begin
            sc_held    = c;
            sc_held_ok = 1'b1;
        end
        if (step_count > 0)
            step_beats[step_count - 1].last = 1'b1;
        for (int i = 0; i < step_count; i++)
            pending_literals.insert(pending_literals.size(), step_beats[i]);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_literals(c, eot);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        texts_sent++;
        text_buf.delete();
    endtask

    function automatic void add_char(logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endfunction

    function automatic void add_digits(int count);
        for (int i = 0; i < count; i++)
            add_char(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic logic [7:0] latin_letter();
        logic [7:0] c;
        case ($urandom_range(3))
            0: c = 8'hAA;
            1: c = 8'hB5;
            2: c = 8'hBA;
            default:
            begin
                c = 8'($urandom_range(8'hFF, 8'hC0));
                if (c == 8'hD7 || c == 8'hF7)
                    c = 8'hFF;
            end
        endcase
        return c;
    endfunction

    function automatic void add_int_token();
        if ($urandom_range(99) < 30)
            add_char(CH_MINUS);
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(4))
                0: add_str("2147483647");
                1: add_str("2147483648");
                2: add_str("2147483649");
                3: add_str("4294967295");
                default: add_str("99999999999");
            endcase
        end
        else if ($urandom_range(99) < 20)
            add_digits($urandom_range(11, 9));
        else
            add_digits($urandom_range(4, 1));
    endfunction

    function automatic void add_float_token();
        add_digits($urandom_range(3, 1));
        case ($urandom_range(7))
            0: begin add_str("."); add_digits($urandom_range(3, 1)); end
            1: begin add_str("."); add_digits($urandom_range(2, 1)); add_str("f"); end
            2: add_str("f");
            3: add_str(".");
            4: begin add_str("."); add_digits(1); add_str("."); add_digits(1); end
            5: add_str("ff");
            6: begin add_str("f"); add_digits(1); end
            default: add_str(".f.");
        endcase
    endfunction

    function automatic void add_comment_body();
        int n;
        n = $urandom_range(6);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(6))
                0: add_str("*");
                1: add_str("/");
                2: add_str(" ");
                3: add_str("x");
                4: add_str("\n");
                default: add_digits(1);
            endcase
        end
    endfunction

    function automatic void add_token();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            add_int_token();
        else if (pick < 40)
            add_float_token();
        else if (pick < 48)
        begin
            if ($urandom_range(3) == 0)
                add_char(latin_letter());
            else if ($urandom_range(3) == 0)
                add_char($urandom_range(1) ? 8'hD7 : 8'hF7);
            else
                add_str($urandom_range(1) ? "x" : "Q");
            if ($urandom_range(1))
                add_str("-");
            add_digits($urandom_range(3, 1));
        end
        else if (pick < 56)
        begin
            add_str("/*");
            add_comment_body();
            if ($urandom_range(9) != 0)
                add_str("*/");
        end
        else if (pick < 62)
        begin
            add_str("//");
            add_comment_body();
            if ($urandom_range(9) != 0)
                add_str("\n");
        end
        else if (pick < 67)
        begin
            add_str("#");
            add_comment_body();
            if ($urandom_range(9) != 0)
                add_str("\n");
        end
        else if (pick < 85)
        begin
            case ($urandom_range(9))
                0: add_str("\n");
                1: add_str(",");
                2: add_str(";");
                3: add_str("(");
                4: add_str("+");
                5: add_str("-");
                6: add_str("*");
                7: add_str("/");
                8: add_str("=");
                default: add_str(" ");
            endcase
        end
        else
        begin
            add_char(8'($urandom_range(255)));
        end
    endfunction

    task automatic test_directed_cases();
        add_str("1-2");
        send_text();
        add_str("x9 -3 1.5f 2..1/");
        send_text();
        add_str("#7\n/*8*/9");
        add_char(8'hC0);
        add_str("4");
        send_text();
    endtask

    task automatic test_random_text(input int sender_idle, input int receiver_stall);
        int first_char;
        int n;
        gap_pct    = sender_idle;
        stall_pct  = receiver_stall;
        first_char = chars_sent;
        while (chars_sent - first_char < 180)
        begin
            n = $urandom_range(20, 3);
            for (int i = 0; i < n; i++)
                add_token();
            send_text();
        end
    endtask

    task automatic test_output_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        hold_len  = HOLD_OFF_CYCLES;
        for (int i = 1; i <= 20; i++)
        begin
            add_digits($urandom_range(3, 1));
            add_str(" ");
        end
        add_str("7");
        send_text();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                m_tready <= 1'b0;
                for (hold_count = 0; hold_count < hold_len; hold_count++)
                    @(posedge clk);
                hold_len = 0;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        nls_pkg::beat_t want;
        nls_pkg::beat_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind      = nls_pkg::kind_t'(m_tuser[0]);
            got.start_pos = m_tdata[19:0];
            got.end_pos   = m_tdata[39:20];
            got.int_value = m_tdata[71:40];
            got.last      = m_tlast;
            if (pending_literals.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected beat: kind %0d start %0d end %0d value %0d last %0d",
                         $time, got.kind, got.start_pos, got.end_pos, got.int_value, got.last);
            end
            else
            begin
                want = pending_literals.pop_front();
                literals_checked++;
                if (got.kind !== want.kind || got.start_pos !== want.start_pos ||
                    got.end_pos !== want.end_pos || got.int_value !== want.int_value ||
                    got.last !== want.last)
                begin
                    err_count++;
                    $display("%0t: expected kind %0d start %0d end %0d value %0d last %0d",
                             $time, want.kind, want.start_pos, want.end_pos, want.int_value,
                             want.last);
                    $display("%0t: actual   kind %0d start %0d end %0d value %0d last %0d",
                             $time, got.kind, got.start_pos, got.end_pos, got.int_value,
                             got.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("FAIL numeric_literal_scanner_unit");
            $finish;
        end
    end

    initial
    begin
        scanner_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_text(0, 0);
        test_random_text(60, 0);
        test_random_text(0, 60);
        test_random_text(38, 38);
        test_output_backpressure();
        s_tvalid <= 1'b0;
        while (pending_literals.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Scanned %0d texts, %0d characters; %0d literal beats checked, %0d errors.",
                 texts_sent, chars_sent, literals_checked, err_count);
        $display("Covered idle and stall mixes plus a %0d-cycle output hold-off.",
                 HOLD_OFF_CYCLES);
        if (err_count == 0)
            $display("PASS numeric_literal_scanner_unit");
        else
            $display("FAIL numeric_literal_scanner_unit");
        $finish;
    end

endmodule
